[design/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg
// shared constants, operation codes and queue entry type
// ----------------------------------------------------------------------------
package msa_pkg;
  localparam int NUM_HASH = 30;
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int HW = $clog2(NUM_HASH);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = 12;
  localparam int SW = 13;
  localparam int DEPTH = NUM_HASH * MAX_COLS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [SW-1:0] MOD_RESET = 13'd4096;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [HW-1:0] hidx;
    logic        bad;   // out of range: mark ignored, read gives zero
  } cmd_t;
endpackage

[design/msa_front.sv]
// ----------------------------------------------------------------------------
// msa_front
// accepts transactions, loads coefficients, classifies the rest into a queue
// ----------------------------------------------------------------------------
module msa_front import msa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        q_valid,
  input  logic        q_ready,
  output cmd_t        q_cmd,
  output logic [5:0]  mul_tab [NUM_HASH],
  output logic [7:0]  add_tab [NUM_HASH]
);
  logic [1:0] op;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [4:0] hi;
  cmd_t e0_r, e1_r;
  logic [1:0] cnt_r;
  logic acc, push, pop;

  assign op  = in_tuser;
  assign row = in_tdata[11:0];
  assign col = in_tdata[21:12];
  assign hi  = in_tdata[26:22];
  // a load waits until every earlier command has left the back end
  assign in_tready = (cnt_r != 2'd2) &&
                     !(op == OP_LOAD && (cnt_r != 2'd0 || !q_ready));
  assign acc  = in_tvalid && in_tready;
  assign push = acc && (op != OP_LOAD);
  assign pop  = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = e0_r;

  always_ff @(posedge clk) begin
    if (acc && op == OP_LOAD && 32'(hi) < NUM_HASH) begin
      mul_tab[hi[HW-1:0]] <= in_tdata[32:27];
      add_tab[hi[HW-1:0]] <= in_tdata[40:33];
    end
  end

  cmd_t nc;
  always_comb begin
    nc.op = op; nc.row = row; nc.col = col; nc.hidx = hi[HW-1:0];
    nc.bad = (op == OP_MARK) ? (32'(col) >= MAX_COLS || 32'(row) >= MAX_ROWS)
                             : (32'(hi) >= NUM_HASH || 32'(col) >= MAX_COLS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      e0_r <= (push && cnt_r == 2'd1) ? nc : e1_r;
      if (push && cnt_r == 2'd2) e1_r <= nc;
    end else if (push) begin
      if (cnt_r == 2'd0) e0_r <= nc;
      else e1_r <= nc;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overfull");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2) else $error("queue count slip");
endmodule

[design/msa_back.sv]
// ----------------------------------------------------------------------------
// msa_back
// executes clear, mark and read on the signature memory
// ----------------------------------------------------------------------------
module msa_back import msa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [SW-1:0] modulus,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_cmd,
  input  logic [5:0]  mul_tab [NUM_HASH],
  input  logic [7:0]  add_tab [NUM_HASH],
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_MUL = 4'd2, S_DIV = 4'd3,
                         S_RD = 4'd4, S_CMP = 4'd5, S_RRD = 4'd6, S_RWT = 4'd7,
                         S_OUT = 4'd8;
  logic [3:0] st_r;
  cmd_t c_r;
  logic [HW-1:0] k_r;
  logic [AW-1:0] a_r;
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rd_r;
  logic [18:0] rem_r;
  logic [4:0]  bit_r;
  logic [SW-1:0] h_r;
  logic [SW-1:0] mod_r;
  logic we;
  logic [AW-1:0] wa;
  logic [SW-1:0] wd;
  logic ov_r;
  logic [SW-1:0] ob_r;

  logic signed [19:0] prod;
  logic [18:0] mag;
  assign prod = $signed({1'b0, mul_tab[k_r]}) * $signed({1'b0, c_r.row})
              + 20'(signed'(add_tab[k_r]));
  assign mag = prod[19] ? 19'(-prod) : prod[18:0];

  logic [AW-1:0] addr;
  assign addr = AW'(32'(k_r) * MAX_COLS + 32'(c_r.col));
  assign q_ready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[a_r];
  end

  // restoring division over the 19 dividend bits, one quotient bit per cycle
  logic [18:0] part_r;
  always_comb begin
    we = 1'b0; wa = a_r; wd = mod_r;
    if (st_r == S_CLR) we = 1'b1;
    if (st_r == S_CMP && h_r < rd_r) begin we = 1'b1; wd = h_r; end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; a_r <= '0; mod_r <= MOD_RESET; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          c_r <= q_cmd; k_r <= '0;
          if (q_cmd.op == OP_CLEAR) begin
            st_r <= S_CLR; a_r <= '0; mod_r <= modulus;
          end else if (q_cmd.op == OP_MARK) begin
            st_r <= q_cmd.bad ? S_IDLE : S_MUL;
          end else if (q_cmd.bad) begin
            ob_r <= '0; st_r <= S_OUT;
          end else begin
            a_r <= AW'(32'(q_cmd.hidx) * MAX_COLS + 32'(q_cmd.col)); st_r <= S_RRD;
          end
        end
        S_CLR: begin
          a_r <= a_r + 1'b1;
          if (32'(a_r) == DEPTH - 1) st_r <= S_IDLE;
        end
        S_MUL: begin
          part_r <= mag; rem_r <= '0; bit_r <= 5'd18; a_r <= addr; st_r <= S_DIV;
        end
        S_DIV: begin
          if (modulus == '0) begin
            h_r <= '0; st_r <= S_RD;
          end else begin
            if ({rem_r[17:0], part_r[bit_r]} >= {6'd0, modulus}) begin
              rem_r <= {rem_r[17:0], part_r[bit_r]} - {6'd0, modulus};
              if (bit_r == 5'd0) h_r <= SW'({rem_r[17:0], part_r[bit_r]} - {6'd0, modulus});
            end else begin
              rem_r <= {rem_r[17:0], part_r[bit_r]};
              if (bit_r == 5'd0) h_r <= SW'({rem_r[17:0], part_r[bit_r]});
            end
            if (bit_r == 5'd0) st_r <= S_RD;
            bit_r <= bit_r - 1'b1;
          end
        end
        S_RD: st_r <= S_CMP;
        S_CMP: begin
          if (32'(k_r) == NUM_HASH - 1) st_r <= S_IDLE;
          else begin k_r <= k_r + 1'b1; st_r <= S_MUL; end
        end
        S_RRD: st_r <= S_RWT;
        S_RWT: begin ob_r <= rd_r; st_r <= S_OUT; end
        S_OUT: if (!ov_r || out_tready) begin ov_r <= 1'b1; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && (!ov_r || out_tready)) out_tdata <= {3'd0, ob_r};
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> ov_r) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready) else $error("ready while busy");
  a_hmin: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD && modulus != '0) |-> h_r < modulus) else $error("hash not reduced");
endmodule

[design/minhash_signature_accumulator_top.sv]
// ----------------------------------------------------------------------------
// minhash_signature_accumulator_top
// MinHash signature matrix builder with a front queue and a memory back end
// ----------------------------------------------------------------------------
// in_ channel: one command per transaction; tuser carries the operation
// (clear, load, mark, read), tdata the row, column, hash index and coefficients.
// out_ channel: one signature per read transaction.
// cfg_: write enable and data for the modulus register.
// load is done in the front, once the queue is empty and the
// back end idle, so it never overtakes an earlier mark.
// mark runs each of the NUM_HASH hashes through the bit-serial remainder unit
// (one bit a cycle), which is bypassed with modulus zero.
// an in-range read steps through S_RRD, S_RWT and S_OUT before out_tvalid rises.
// clear sweeps all NUM_HASH*MAX_COLS = 30720 entries, one per cycle.
// after reset the same clearing pass runs with modulus 4096;
// commands queue up in a two-entry queue meanwhile.
// a stalled receiver holds the result; the back end waits, the queue fills,
// and then in_tready falls.
// ----------------------------------------------------------------------------
module minhash_signature_accumulator_top import msa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row, col, hash_index, coef_mul, coef_add
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // signature
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);
  logic [SW-1:0] modulus_r;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  logic [5:0] mul_tab [NUM_HASH];
  logic [7:0] add_tab [NUM_HASH];

  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= MOD_RESET;
    else if (cfg_we) modulus_r <= cfg_wdata;
  end

  msa_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_ready, .q_cmd, .mul_tab, .add_tab);
  msa_back u_back (.clk, .rst_n, .modulus(modulus_r), .q_valid, .q_ready, .q_cmd,
    .mul_tab, .add_tab, .out_tvalid, .out_tready, .out_tdata);
endmodule

[bench/minhash_signature_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_checker
// watches the command, result and modulus ports, keeps its own copy of the
// signature matrix and coefficient tables, and compares every returned
// signature with the oldest predicted one
// ----------------------------------------------------------------------------
module minhash_signature_checker import msa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);

  logic [SW-1:0]     sig_mem [NUM_HASH*MAX_COLS];
  logic [5:0]        mul_tab [NUM_HASH];
  logic signed [7:0] add_tab [NUM_HASH];
  logic [SW-1:0]     modulus_q;
  logic [SW-1:0]     signature_queue [$];

  function automatic logic [SW-1:0] hash_value(int k, logic [RW-1:0] r);
    longint s;
    s = longint'(mul_tab[k]) * longint'(r) + longint'(add_tab[k]);
    if (s < 0) s = -s;
    if (modulus_q == 0) return '0;
    return SW'(s % longint'(modulus_q));
  endfunction

  task automatic clear_matrix();
    for (int i = 0; i < NUM_HASH*MAX_COLS; i++) sig_mem[i] = modulus_q;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [1:0]    op;
    logic [RW-1:0] row;
    logic [CW-1:0] col;
    logic [4:0]    hidx;
    logic [SW-1:0] want, h;
    if (!rst_n) begin
      modulus_q = MOD_RESET;
      signature_queue.delete();
      clear_matrix();
    end else begin
      if (out_tvalid && out_tready) begin
        if (signature_queue.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transaction: signature %0d", out_tdata[SW-1:0]);
          mismatches++;
        end else begin
          want = signature_queue.pop_front();
          if (out_tdata[SW-1:0] !== want) begin
            if (mismatches < 10)
              $display("signature mismatch: expected %0d, got %0d", want,
                       out_tdata[SW-1:0]);
            mismatches++;
          end
        end
      end
      if (cfg_we) modulus_q = cfg_wdata;
      if (in_tvalid && in_tready) begin
        op   = in_tuser;
        row  = in_tdata[11:0];
        col  = in_tdata[21:12];
        hidx = in_tdata[26:22];
        case (op)
          OP_CLEAR: clear_matrix();
          OP_LOAD: begin
            if (hidx < NUM_HASH) begin
              mul_tab[hidx] = in_tdata[32:27];
              add_tab[hidx] = in_tdata[40:33];
            end
          end
          OP_MARK: begin
            for (int k = 0; k < NUM_HASH; k++) begin
              h = hash_value(k, row);
              if (h < sig_mem[k*MAX_COLS + col]) sig_mem[k*MAX_COLS + col] = h;
            end
          end
          default: begin
            if (hidx < NUM_HASH) signature_queue.push_back(sig_mem[hidx*MAX_COLS + col]);
            else signature_queue.push_back('0);
          end
        endcase
      end
    end
    pending = signature_queue.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus for the minhash signature accumulator: directed loads, marks,
// reads and clears, then random command streams under several modulus values,
// with random idling on both sides, a long receiver hold-off and a drain pause
// ----------------------------------------------------------------------------
module testbench import msa_pkg::*;;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // row, col, hash_index, coef_mul, coef_add
  logic [1:0]  in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // signature
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  int          mismatches;
  int          pending;
  bit          calm;
  bit          hold_req;
  bit          held;
  int          hold_cnt;
  int          quiet_cycles;

  minhash_signature_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  minhash_signature_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    hold_cnt = 0;
    held = 0;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        hold_cnt = 3000;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 500000) begin
        $display("minhash_signature_accumulator_top test failed");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [11:0] row, logic [9:0] col,
                      logic [4:0] hidx, logic [5:0] mul, logic [7:0] add);
    if (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'b0, add, mul, hidx, col, row};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // a read behind every earlier command returns only once the block is idle
  task automatic write_modulus(logic [12:0] value);
    send(OP_READ, '0, '0, '0, '0, '0);
    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 0;
    @(posedge clk);
  endtask

  task automatic random_command(int n);
    int        pick;
    logic [9:0] col;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(999);
      col = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(15));
      if (pick < 3)
        send(OP_CLEAR, 12'($urandom), col, 5'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < 100)
        send(OP_LOAD, 12'($urandom), col, 5'($urandom), 6'($urandom), 8'($urandom));
      else if (pick < 300)
        send(OP_MARK, 12'($urandom), col, 5'($urandom), 6'($urandom), 8'($urandom));
      else
        send(OP_READ, 12'($urandom), col, 5'($urandom), 6'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [12:0] moduli [6];
    moduli = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd37, 13'd4096};
    calm      = 0;
    hold_req  = 0;
    rst_n     = 0;
    in_tvalid = 0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_we    = 0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // all hashes loaded before any mark
    for (int k = 0; k < NUM_HASH; k++)
      send(OP_LOAD, '0, '0, 5'(k), 6'($urandom) | 6'd1, 8'($urandom));
    send(OP_LOAD, '0, '0, 5'd0, 6'd63, 8'h7f);
    send(OP_LOAD, '0, '0, 5'd1, 6'd0, 8'h80);
    send(OP_LOAD, '0, '0, 5'd2, 6'd2, 8'hff);
    send(OP_LOAD, '0, '0, 5'd31, 6'd5, 8'd1);
    send(OP_READ, '0, 10'd0, 5'd0, '0, '0);
    send(OP_READ, '0, 10'd1023, 5'd29, '0, '0);
    send(OP_MARK, 12'd0, 10'd0, '0, '0, '0);
    send(OP_MARK, 12'd4095, 10'd1023, 5'd31, 6'd63, 8'hff);
    send(OP_MARK, 12'd1234, 10'd0, '0, '0, '0);
    for (int k = 0; k < 3; k++) send(OP_READ, '0, 10'd0, 5'(k), '0, '0);
    send(OP_READ, '0, 10'd1023, 5'd0, '0, '0);
    send(OP_READ, '0, 10'd1023, 5'd29, '0, '0);
    send(OP_READ, '0, 10'd0, 5'd30, '0, '0);
    send(OP_READ, '0, 10'd0, 5'd31, '0, '0);
    send(OP_CLEAR, '0, '0, '0, '0, '0);
    send(OP_READ, '0, 10'd0, 5'd0, '0, '0);

    for (int p = 0; p < 6; p++) begin
      write_modulus(moduli[p]);
      if (p != 2) send(OP_CLEAR, '0, '0, '0, '0, '0);
      if (p == 1) begin
        hold_req = 1;
        for (int i = 0; i < 12; i++) send(OP_READ, '0, 10'($urandom_range(15)),
                                          5'($urandom_range(29)), '0, '0);
      end
      if (p == 3) calm = 1;
      random_command(115);
      calm = 0;
      in_tvalid <= 0;
      @(posedge clk);
      wait (pending == 0);
      @(posedge clk);
      random_command(115);
    end

    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (800) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("minhash_signature_accumulator_top test passed");
    else
      $display("minhash_signature_accumulator_top test failed");
    $finish;
  end

endmodule
